// File: sv/spqt_pkg.sv
// Package for the shared pool quota table: sizes, payload structs, status codes
// and the command and status structs between controller and datapath.
// No dependencies.
package spqt_pkg;

  localparam int CLIENTS   = 64;
  localparam int FRAC_BITS = 8;
  localparam int CLIENT_W  = $clog2(CLIENTS);
  localparam int IDX_W     = 6;
  localparam int AMT_W     = 32;
  localparam int BAL_W     = 40;
  localparam int CFG_IDX_W = 3;

  localparam logic [AMT_W-1:0] FRAC_MASK = AMT_W'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [BAL_W-1:0] BAL_MAX   = {BAL_W{1'b1}};

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_XFER  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_EN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_EN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WHOLE      = 3'd4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NONPOS   = 3'd1,
    ST_AFRAC    = 3'd2,
    ST_POOL     = 3'd3,
    ST_CAP      = 3'd4,
    ST_NEGFREE  = 3'd5,
    ST_FFRAC    = 3'd6,
    ST_OVERFREE = 3'd7
  } status_t;

  typedef struct packed {
    logic [1:0]              func;
    logic [IDX_W-1:0]        client;
    logic [IDX_W-1:0]        beneficiary;
    logic signed [AMT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [BAL_W-1:0] client_balance;
    logic [BAL_W-1:0] beneficiary_balance;
    logic [BAL_W-1:0] pool_total;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_ALLOC_C,
    OP_FREE_C,
    OP_ALLOC_B
  } dp_op_t;

  typedef struct packed {
    logic   accept;
    dp_op_t op;
    logic   wr_b;
    logic   wr_c;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       fail;
  } dp_stat_t;

  function automatic logic [CLIENT_W-1:0] client_index(input logic [IDX_W-1:0] c);
    return CLIENT_W'(32'(c) % CLIENTS);
  endfunction

  function automatic logic [BAL_W-1:0] sat_add(input logic [BAL_W-1:0] a,
                                               input logic [BAL_W-1:0] b);
    logic [BAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BAL_W] ? BAL_MAX : s[BAL_W-1:0];
  endfunction

  function automatic logic [BAL_W-1:0] sat_sub(input logic [BAL_W-1:0] a,
                                               input logic [BAL_W-1:0] b);
    return (a < b) ? '0 : a - b;
  endfunction

endpackage

// File: sv/spqt_ctrl.sv
// Controller of the shared pool quota table: sequences accept, free, allocate,
// write back and result transfer. Depends on spqt_pkg.
module spqt_ctrl
  import spqt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP1,
    S_OP2,
    S_WRB,
    S_WRC
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '{accept: 1'b0, op: OP_HOLD, wr_b: 1'b0, wr_c: 1'b0, out_load: 1'b0};
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall_r) begin
          cmd.accept = 1'b1;
          state_nxt  = S_OP1;
        end
      end
      S_OP1: begin
        case (stat.func)
          FUNC_ALLOC: cmd.op = OP_ALLOC_C;
          FUNC_FREE:  cmd.op = OP_FREE_C;
          FUNC_XFER:  cmd.op = OP_FREE_C;
          default:    cmd.op = OP_LOAD;
        endcase
        state_nxt = (stat.func == FUNC_XFER) ? S_OP2 : S_WRC;
      end
      S_OP2: begin
        if (stat.fail) begin
          state_nxt = S_WRC;
        end else begin
          cmd.op    = OP_ALLOC_B;
          state_nxt = S_WRB;
        end
      end
      S_WRB: begin
        cmd.wr_b  = 1'b1;
        state_nxt = S_WRC;
      end
      S_WRC: begin
        if (!out_valid_r || !out_stall) begin
          cmd.wr_c      = 1'b1;
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    in_stall_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_stall_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= in_stall_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

endmodule

// File: sv/spqt_dp.sv
// Datapath of the shared pool quota table: balance memory, configuration
// registers, free and allocate arithmetic and the result register. Depends on spqt_pkg.
module spqt_dp
  import spqt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BAL_W-1:0]     cfg_wdata,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output out_item_t            out_data
);

  logic [BAL_W-1:0] mem [CLIENTS];
  logic [BAL_W-1:0] mem_c_q, mem_b_q;
  logic             vld_c_q, vld_b_q;
  logic [CLIENTS-1:0] vld_r;

  logic             pool_en_r, cap_en_r, whole_r;
  logic [BAL_W-1:0] pool_limit_r, cap_r;

  logic [1:0]          func_r;
  logic [CLIENT_W-1:0] cidx_r, bidx_r;
  logic                same_r;
  logic [AMT_W-1:0]    amt_r;

  logic [BAL_W-1:0] bal_c_r, bal_c_nxt, bal_b_r, bal_b_nxt;
  logic [BAL_W-1:0] total_r, total_nxt, freed_r, freed_nxt;
  status_t          status_r, status_nxt;
  out_item_t        out_r;

  logic [CLIENT_W-1:0] in_cidx, in_bidx;
  logic             first, amt_neg, amt_zero, frac;
  logic [BAL_W-1:0] rd_c, rd_b, bc, bb, bx, u;
  logic [BAL_W:0]   pool_sum, bal_sum;
  status_t          alloc_st, free_st;
  logic [BAL_W-1:0] alloc_bal, alloc_tot, free_u, free_bal, free_tot, rest_c, rest_tot;

  assign in_cidx = client_index(in_data.client);
  assign in_bidx = client_index(in_data.beneficiary);

  always_comb begin
    first    = (cmd.op == OP_LOAD) || (cmd.op == OP_ALLOC_C) || (cmd.op == OP_FREE_C);
    rd_c     = vld_c_q ? mem_c_q : '0;
    rd_b     = vld_b_q ? mem_b_q : '0;
    bc       = first ? rd_c : bal_c_r;
    bb       = first ? rd_b : bal_b_r;
    bx       = (cmd.op == OP_ALLOC_B) ? bal_b_r : bc;
    amt_neg  = amt_r[AMT_W-1];
    amt_zero = (amt_r == '0);
    frac     = whole_r && ((amt_r & FRAC_MASK) != '0);
    u        = BAL_W'(amt_r[AMT_W-2:0]);

    pool_sum = {1'b0, u} + {1'b0, total_r};
    bal_sum  = {1'b0, u} + {1'b0, bx};
    if (amt_neg || amt_zero) begin
      alloc_st = ST_NONPOS;
    end else if (frac) begin
      alloc_st = ST_AFRAC;
    end else if (pool_en_r && (pool_sum > {1'b0, pool_limit_r})) begin
      alloc_st = ST_POOL;
    end else if (cap_en_r && (bal_sum > {1'b0, cap_r})) begin
      alloc_st = ST_CAP;
    end else begin
      alloc_st = ST_OK;
    end
    alloc_bal = bal_sum[BAL_W] ? BAL_MAX : bal_sum[BAL_W-1:0];
    alloc_tot = pool_sum[BAL_W] ? BAL_MAX : pool_sum[BAL_W-1:0];

    if (amt_neg) begin
      free_st = ST_NEGFREE;
    end else if (frac) begin
      free_st = ST_FFRAC;
    end else if ((bx == '0) || (bx < u)) begin
      free_st = ST_OVERFREE;
    end else begin
      free_st = ST_OK;
    end
    free_u   = amt_zero ? bx : u;
    free_bal = amt_zero ? '0 : bx - u;
    free_tot = amt_zero ? sat_sub(total_r, bx) : sat_sub(total_r, u);

    rest_c   = sat_add(bal_c_r, freed_r);
    rest_tot = sat_add(total_r, freed_r);

    bal_c_nxt  = bal_c_r;
    bal_b_nxt  = bal_b_r;
    total_nxt  = total_r;
    freed_nxt  = freed_r;
    status_nxt = status_r;
    case (cmd.op)
      OP_LOAD: begin
        bal_c_nxt  = bc;
        bal_b_nxt  = bb;
        status_nxt = ST_OK;
      end
      OP_ALLOC_C: begin
        status_nxt = alloc_st;
        bal_c_nxt  = bc;
        bal_b_nxt  = bb;
        if (alloc_st == ST_OK) begin
          bal_c_nxt = alloc_bal;
          bal_b_nxt = same_r ? alloc_bal : bb;
          total_nxt = alloc_tot;
        end
      end
      OP_FREE_C: begin
        status_nxt = free_st;
        freed_nxt  = free_u;
        bal_c_nxt  = bc;
        bal_b_nxt  = bb;
        if (free_st == ST_OK) begin
          bal_c_nxt = free_bal;
          bal_b_nxt = same_r ? free_bal : bb;
          total_nxt = free_tot;
        end
      end
      OP_ALLOC_B: begin
        status_nxt = alloc_st;
        if (alloc_st == ST_OK) begin
          bal_b_nxt = alloc_bal;
          bal_c_nxt = same_r ? alloc_bal : bal_c_r;
          total_nxt = alloc_tot;
        end else begin
          bal_c_nxt = rest_c;
          bal_b_nxt = same_r ? rest_c : bal_b_r;
          total_nxt = rest_tot;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem_c_q <= mem[in_cidx];
      mem_b_q <= mem[in_bidx];
    end
    if (cmd.wr_b) begin
      mem[bidx_r] <= bal_b_r;
    end else if (cmd.wr_c) begin
      mem[cidx_r] <= bal_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      vld_c_q      <= 1'b0;
      vld_b_q      <= 1'b0;
      total_r      <= '0;
      pool_en_r    <= 1'b0;
      pool_limit_r <= '0;
      cap_en_r     <= 1'b0;
      cap_r        <= '0;
      whole_r      <= 1'b0;
    end else begin
      if (cmd.accept) begin
        vld_c_q <= vld_r[in_cidx];
        vld_b_q <= vld_r[in_bidx];
      end
      if (cmd.wr_b) begin
        vld_r[bidx_r] <= 1'b1;
      end else if (cmd.wr_c) begin
        vld_r[cidx_r] <= 1'b1;
      end
      total_r <= total_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POOL_EN:    pool_en_r    <= cfg_wdata[0];
          CFG_POOL_LIMIT: pool_limit_r <= cfg_wdata;
          CFG_CAP_EN:     cap_en_r     <= cfg_wdata[0];
          CFG_CAP:        cap_r        <= cfg_wdata;
          CFG_WHOLE:      whole_r      <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= in_data.func;
      cidx_r <= in_cidx;
      bidx_r <= in_bidx;
      same_r <= (in_cidx == in_bidx);
      amt_r  <= in_data.amount;
    end
    bal_c_r  <= bal_c_nxt;
    bal_b_r  <= bal_b_nxt;
    freed_r  <= freed_nxt;
    status_r <= status_nxt;
    if (cmd.out_load) begin
      out_r.status              <= status_r;
      out_r.client_balance      <= bal_c_r;
      out_r.beneficiary_balance <= bal_b_r;
      out_r.pool_total          <= total_r;
    end
  end

  assign stat.func = func_r;
  assign stat.fail = (status_r != ST_OK);
  assign out_data  = out_r;

endmodule

// File: sv/shared_pool_quota_table.sv
// Shared pool quota table. One request at a time: an allocate, a free or any other code
// runs one step, then writes the client entry back and loads the output register; a
// transfer runs a free step, then, if it succeeded, an allocate step and the beneficiary
// write, then the client write, one at a time through the single write port of the
// balance memory. The table clears at reset through per-entry valid bits, so no clearing
// pass is needed. The next request is taken once the previous one is written back, even
// while its result waits in the output register. Depends on spqt_pkg, spqt_ctrl, spqt_dp.
module shared_pool_quota_table
  import spqt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BAL_W-1:0]     cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  spqt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  spqt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
